@@ sv/assert_macros.svh @@
// assertion macros for the asserting rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define VSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define VSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/vsc_pkg.sv @@
// shared types and constants of the viewport segment clipper
package vsc_pkg;

  localparam int IN_W    = 16;
  localparam int CLIP_W  = 15;
  localparam int COLOR_W = 24;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CAMERA_X    = 3'd0,
    REG_CAMERA_Y    = 3'd1,
    REG_SCALE_X     = 3'd2,
    REG_SCALE_Y     = 3'd3,
    REG_CLIP_LEFT   = 3'd4,
    REG_CLIP_TOP    = 3'd5,
    REG_CLIP_WIDTH  = 3'd6,
    REG_CLIP_HEIGHT = 3'd7
  } vsc_reg_t;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_XOUT  = 2'd1,
    MODE_YONLY = 2'd2
  } vsc_mode_t;

endpackage

@@ sv/vsc_project.sv @@
// one projection lane: subtract camera, scale, truncate, add origin, saturate
module vsc_project #(
  parameter int FRAC_BITS  = 8,
  parameter int COORD_BITS = 16,
  parameter int IW         = 17
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [vsc_pkg::IN_W-1:0]   coord,
  input  logic signed [vsc_pkg::IN_W-1:0]   cam,
  input  logic        [vsc_pkg::IN_W-1:0]   scale,
  input  logic        [vsc_pkg::CLIP_W-1:0] origin,
  input  logic                        org_en,
  output logic signed [IW-1:0]        proj
);
  import vsc_pkg::*;

  localparam int DW = IN_W + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam logic signed [PW-1:0] BIAS = PW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO = SW'(-(64'sd1 <<< (COORD_BITS - 1)));

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] shifted;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] clamped;

  always_comb begin
    rnd     = prod + (prod[PW-1] ? BIAS : '0);
    shifted = rnd >>> FRAC_BITS;
    sum     = SW'(shifted) + (org_en ? $signed(SW'(origin)) : '0);
    if (sum > HI) begin
      clamped = HI;
    end else if (sum < LO) begin
      clamped = LO;
    end else begin
      clamped = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= DW'(coord) - DW'(cam);
      prod <= diff * $signed({1'b0, scale});
      proj <= IW'(clamped);
    end
  end

endmodule

@@ sv/vsc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module vsc_div #(
  parameter int NW = 37,
  parameter int DW = 18,
  parameter int QB = 17,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QB-1:0] quo,
  output logic [SW-1:0] side_out
);
  import vsc_pkg::*;

  logic          v   [QB+1];
  logic [NW-1:0] rem [QB+1];
  logic [DW-1:0] dv  [QB+1];
  logic [QB-1:0] q   [QB+1];
  logic [SW-1:0] sd  [QB+1];

  assign v[0]   = in_valid;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [NW-1:0] trial;
    logic          ge;
    logic [QB-1:0] q_next;

    always_comb begin
      trial      = NW'(dv[k]) << SH;
      ge         = rem[k] >= trial;
      q_next     = q[k];
      q_next[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - trial : rem[k];
        dv[k+1]  <= dv[k];
        q[k+1]   <= q_next;
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = v[QB];
  assign quo       = q[QB];
  assign side_out  = sd[QB];

endmodule

@@ sv/vsc_interp.sv @@
// pipelined line interpolation: b at a = at, truncated toward zero
module vsc_interp #(
  parameter int IW = 17,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] a0,
  input  logic signed [IW-1:0] b0,
  input  logic signed [IW-1:0] a1,
  input  logic signed [IW-1:0] b1,
  input  logic signed [IW-1:0] at,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [IW-1:0] res,
  output logic [SW-1:0]        side_out
);
  import vsc_pkg::*;

  localparam int EW  = IW + 1;
  localparam int MW  = 2 * IW + 2;
  localparam int NW  = 2 * IW + 3;
  localparam int DSW = SW + 2 + IW;

  logic                 v1, v2, v3;
  logic signed [EW-1:0] den1, db1, da1;
  logic signed [IW-1:0] b0_1, b0_2, b0_3;
  logic [SW-1:0]        s1, s2, s3;
  logic signed [MW-1:0] m1, m2;
  logic signed [EW-1:0] den2;
  logic [NW-1:0]        mag3;
  logic [EW-1:0]        dena3;
  logic                 neg3, den0_3;

  logic signed [NW-1:0] num, num_n;
  logic signed [EW-1:0] den_n;
  logic                 dneg;

  always_comb begin
    dneg  = den2[EW-1];
    num   = NW'(m1) + NW'(m2);
    num_n = dneg ? -num : num;
    den_n = dneg ? -den2 : den2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den1   <= EW'(a1) - EW'(a0);
      db1    <= EW'(b1) - EW'(b0);
      da1    <= EW'(at) - EW'(a0);
      b0_1   <= b0;
      s1     <= side_in;
      m1     <= MW'(b0_1 * den1);
      m2     <= db1 * da1;
      den2   <= den1;
      b0_2   <= b0_1;
      s2     <= s1;
      neg3   <= num_n[NW-1];
      mag3   <= num_n[NW-1] ? NW'(-num_n) : NW'(num_n);
      dena3  <= den_n;
      den0_3 <= den2 == '0;
      b0_3   <= b0_2;
      s3     <= s2;
    end
  end

  logic           dv;
  logic [IW-1:0]  dq;
  logic [DSW-1:0] dside;
  logic           neg_d, den0_d;
  logic [IW-1:0]  b0_d;
  logic [SW-1:0]  s_d;
  logic [EW-1:0]  qs;

  vsc_div #(.NW(NW), .DW(EW), .QB(IW), .SW(DSW)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .num(mag3), .den(dena3), .side_in({neg3, den0_3, b0_3, s3}),
    .out_valid(dv), .quo(dq), .side_out(dside)
  );

  assign {neg_d, den0_d, b0_d, s_d} = dside;
  assign qs = neg_d ? -EW'(dq) : EW'(dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res      <= den0_d ? $signed(b0_d) : $signed(qs[IW-1:0]);
      side_out <= s_d;
    end
  end

endmodule

@@ sv/viewport_segment_clipper_top.sv @@
// viewport segment clipper: projection, window test and border clipping
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  input   | in        | in_valid / in_ready   | kind, start_x/y, end_x/y, color
//  result  | out       | out_valid / out_ready | out_kind, screen_x1/y1/x2/y2, out_color
//  config  | in        | cfg_we                | cfg_index, cfg_data
//
// one transfer per cycle sustained while the result side takes every result; the
// path runs through the projection stages, two interpolators and the output
// register, where IW = max(COORD_BITS, 16) + 1 sets the divider depth (one quotient bit a stage)
// reset (synchronous, active high) clears all valid bits and loads the register
// defaults; payload registers are not reset
// the whole pipeline advances when the output register is empty or taken, so a
// stall freezes every stage in place and in_ready follows it
// dropped items leave a bubble and produce no result transfer
module viewport_segment_clipper_top #(
  parameter int FRAC_BITS  = 8,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic signed [vsc_pkg::IN_W-1:0]    start_x,
  input  logic signed [vsc_pkg::IN_W-1:0]    start_y,
  input  logic signed [vsc_pkg::IN_W-1:0]    end_x,
  input  logic signed [vsc_pkg::IN_W-1:0]    end_y,
  input  logic        [vsc_pkg::COLOR_W-1:0] color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_kind,
  output logic signed [vsc_pkg::IN_W-1:0]    screen_x1,
  output logic signed [vsc_pkg::IN_W-1:0]    screen_y1,
  output logic signed [vsc_pkg::IN_W-1:0]    screen_x2,
  output logic signed [vsc_pkg::IN_W-1:0]    screen_y2,
  output logic        [vsc_pkg::COLOR_W-1:0] out_color,
  input  logic                               cfg_we,
  input  logic        [vsc_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [vsc_pkg::IN_W-1:0]    cfg_data
);
  import vsc_pkg::*;
  `include "assert_macros.svh"

  // internal coordinate width holds saturated coords and window borders
  localparam int IW  = (COORD_BITS > IN_W ? COORD_BITS : IN_W) + 1;
  localparam int SW1 = 5 + 5 * IW + COLOR_W;
  localparam int SW2 = 5 + 4 * IW + COLOR_W;
  localparam logic signed [IW-1:0] SAT_HI = IW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [IW-1:0] SAT_LO = IW'(-(64'sd1 <<< (COORD_BITS - 1)));

  function automatic logic [IN_W-1:0] sat_out(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return c[IN_W-1:0];
  endfunction

  // configuration registers
  logic signed [IN_W-1:0] camera_x, camera_y;
  logic [IN_W-1:0]        scale_x, scale_y;
  logic [CLIP_W-1:0]      clip_left, clip_top, clip_width, clip_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x    <= '0;
      camera_y    <= '0;
      scale_x     <= 16'd256;
      scale_y     <= 16'd256;
      clip_left   <= '0;
      clip_top    <= '0;
      clip_width  <= '0;
      clip_height <= '0;
    end else if (cfg_we) begin
      case (vsc_reg_t'(cfg_index))
        REG_CAMERA_X:    camera_x    <= cfg_data;
        REG_CAMERA_Y:    camera_y    <= cfg_data;
        REG_SCALE_X:     scale_x     <= cfg_data;
        REG_SCALE_Y:     scale_y     <= cfg_data;
        REG_CLIP_LEFT:   clip_left   <= cfg_data[CLIP_W-1:0];
        REG_CLIP_TOP:    clip_top    <= cfg_data[CLIP_W-1:0];
        REG_CLIP_WIDTH:  clip_width  <= cfg_data[CLIP_W-1:0];
        REG_CLIP_HEIGHT: clip_height <= cfg_data[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // window; the user keeps it stable while items are in flight, the block does not enforce this
  logic                 ena_x, ena_y, clip_on;
  logic signed [IW-1:0] bl, br, bt, bb;

  assign ena_x   = (clip_left != '0) && (clip_width != '0);
  assign ena_y   = (clip_top != '0) && (clip_height != '0);
  assign clip_on = ena_x || ena_y;
  assign bl = $signed(IW'(clip_left));
  assign bt = $signed(IW'(clip_top));
  assign br = $signed(IW'({1'b0, clip_left} + {1'b0, clip_width}));
  assign bb = $signed(IW'({1'b0, clip_top} + {1'b0, clip_height}));

  // global advance: output register empty or being taken
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // projection stages, valid and side data run alongside the lanes
  logic               pv    [3];
  logic               pkind [3];
  logic [COLOR_W-1:0] pcol  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
      pv[1] <= 1'b0;
      pv[2] <= 1'b0;
    end else if (en) begin
      pv[0] <= in_valid;
      pv[1] <= pv[0];
      pv[2] <= pv[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkind[0] <= kind;
      pcol[0]  <= color;
      pkind[1] <= pkind[0];
      pcol[1]  <= pcol[0];
      pkind[2] <= pkind[1];
      pcol[2]  <= pcol[1];
    end
  end

  logic signed [IW-1:0] px1, py1, px2, py2;

  vsc_project #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS), .IW(IW)) u_px1 (
    .clk(clk), .en(en), .coord(start_x), .cam(camera_x), .scale(scale_x),
    .origin(clip_left), .org_en(ena_x), .proj(px1)
  );
  vsc_project #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS), .IW(IW)) u_py1 (
    .clk(clk), .en(en), .coord(start_y), .cam(camera_y), .scale(scale_y),
    .origin(clip_top), .org_en(ena_y), .proj(py1)
  );
  vsc_project #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS), .IW(IW)) u_px2 (
    .clk(clk), .en(en), .coord(end_x), .cam(camera_x), .scale(scale_x),
    .origin(clip_left), .org_en(ena_x), .proj(px2)
  );
  vsc_project #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS), .IW(IW)) u_py2 (
    .clk(clk), .en(en), .coord(end_y), .cam(camera_y), .scale(scale_y),
    .origin(clip_top), .org_en(ena_y), .proj(py2)
  );

  // window test and choice of inner and outer end
  logic                 in1, in2;
  logic                 c_alive, c_swap;
  vsc_mode_t            c_mode;
  logic signed [IW-1:0] c_ix, c_iy, c_ox, c_oy, c_bord;

  always_comb begin
    in1     = (px1 > bl) && (px1 < br) && (py1 > bt) && (py1 < bb);
    in2     = (px2 > bl) && (px2 < br) && (py2 > bt) && (py2 < bb);
    c_alive = 1'b1;
    c_swap  = 1'b0;
    c_mode  = MODE_PASS;
    c_ix    = px1;
    c_iy    = py1;
    c_ox    = px2;
    c_oy    = py2;
    c_bord  = bl;
    if (pkind[2]) begin
      // point: second end repeats the first
      c_ox    = px1;
      c_oy    = py1;
      c_alive = !clip_on || in1;
    end else if (clip_on && !(in1 && in2)) begin
      if (!in1 && !in2) begin
        c_alive = 1'b0;
      end else begin
        if (in2) begin
          c_swap = 1'b1;
          c_ix   = px2;
          c_iy   = py2;
          c_ox   = px1;
          c_oy   = py1;
        end
        if ((c_ox > br) || (c_ox < bl)) begin
          c_mode = MODE_XOUT;
          c_bord = (c_ox > br) ? br : bl;
        end else if (c_oy <= bt) begin
          c_mode = MODE_YONLY;
          c_bord = bt;
        end else if (c_oy >= bb) begin
          c_mode = MODE_YONLY;
          c_bord = bb;
        end else begin
          // outer end sits exactly on a vertical border
          c_alive = 1'b0;
        end
      end
    end
  end

  // first interpolation: y on the crossed vertical border
  logic                 i1_v;
  logic signed [IW-1:0] q1;
  logic [SW1-1:0]       s1;
  logic                 k1, a1, w1;
  logic [1:0]           m1_raw;
  logic signed [IW-1:0] ix1, iy1, ox1, oy1, bord1;
  logic [COLOR_W-1:0]   col1;

  vsc_interp #(.IW(IW), .SW(SW1)) u_interp_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(pv[2]),
    .a0(c_ix), .b0(c_iy), .a1(c_ox), .b1(c_oy), .at(c_bord),
    .side_in({pkind[2], c_alive, c_swap, c_mode, c_ix, c_iy, c_ox, c_oy, c_bord, pcol[2]}),
    .out_valid(i1_v), .res(q1), .side_out(s1)
  );

  assign {k1, a1, w1, m1_raw, ix1, iy1, ox1, oy1, bord1, col1} = s1;

  // decide whether the horizontal border is needed
  logic                 use_q2, chk_q2;
  logic signed [IW-1:0] fx, fy, at2, ny2;

  always_comb begin
    ny2    = (q1 <= bt) ? bt : bb;
    use_q2 = 1'b0;
    chk_q2 = 1'b0;
    fx     = ox1;
    fy     = oy1;
    at2    = bord1;
    case (vsc_mode_t'(m1_raw))
      MODE_XOUT: begin
        if ((q1 > bt) && (q1 < bb)) begin
          fx = bord1;
          fy = q1;
        end else begin
          fy     = ny2;
          at2    = ny2;
          use_q2 = 1'b1;
        end
      end
      MODE_YONLY: begin
        fy     = bord1;
        use_q2 = 1'b1;
        chk_q2 = 1'b1;
      end
      default: ;
    endcase
  end

  // second interpolation: x on the horizontal border
  logic                 i2_v;
  logic signed [IW-1:0] q2;
  logic [SW2-1:0]       s2;
  logic                 k2, a2, w2, u2, ch2;
  logic signed [IW-1:0] ix2, iy2, fx2, fy2;
  logic [COLOR_W-1:0]   col2;

  vsc_interp #(.IW(IW), .SW(SW2)) u_interp_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(i1_v),
    .a0(iy1), .b0(ix1), .a1(oy1), .b1(ox1), .at(at2),
    .side_in({k1, a1, w1, use_q2, chk_q2, ix1, iy1, fx, fy, col1}),
    .out_valid(i2_v), .res(q2), .side_out(s2)
  );

  assign {k2, a2, w2, u2, ch2, ix2, iy2, fx2, fy2, col2} = s2;

  // final outer end, last drop check and reassembly in input order
  logic                 f_alive;
  logic signed [IW-1:0] f_ox;

  always_comb begin
    f_ox    = u2 ? q2 : fx2;
    f_alive = a2 && !(ch2 && !((q2 > bl) && (q2 < br)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= i2_v && f_alive;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind  <= k2;
      out_color <= col2;
      screen_x1 <= sat_out(w2 ? f_ox : ix2);
      screen_y1 <= sat_out(w2 ? fy2 : iy2);
      screen_x2 <= sat_out(w2 ? ix2 : f_ox);
      screen_y2 <= sat_out(w2 ? iy2 : fy2);
    end
  end

  // checks
  `VSC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")
  `VSC_ASSERT(a_stall_blocks_input, (out_valid && !out_ready) |-> !in_ready,
              "input taken while result stalled")
  `VSC_ASSERT(a_point_ends_equal,
              out_valid && out_kind |-> (screen_x1 == screen_x2) && (screen_y1 == screen_y2),
              "point result with differing ends")

endmodule

@@ sim/viewport_segment_clipper_top_test.sv @@
// testbench of the viewport segment clipper: directed table, random edges and points, scoreboard
`timescale 1ns / 1ps

module viewport_segment_clipper_top_test;
  import vsc_pkg::*;

  localparam int  DRAIN_CYCLES = 200;
  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  ITEMS_PER_SET = 206;
  localparam int  N_SETS = 8;

  // one primitive on the result side
  typedef struct packed {
    logic               kind;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic [23:0]        col;
  } prim_t;

  // directed row: typed expectation only where it is obvious
  typedef struct packed {
    logic               kind;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [23:0]        col;
    logic               typed;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = 1'b0;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic signed [15:0] end_x = '0;
  logic signed [15:0] end_y = '0;
  logic [23:0]        color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic signed [15:0] screen_x1;
  logic signed [15:0] screen_y1;
  logic signed [15:0] screen_x2;
  logic signed [15:0] screen_y2;
  logic [23:0]        out_color;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  viewport_segment_clipper_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y), .color(color),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .screen_x1(screen_x1), .screen_y1(screen_y1),
    .screen_x2(screen_x2), .screen_y2(screen_y2), .out_color(out_color),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow copy of the register file
  longint cam_x = 0, cam_y = 0, scl_x = 256, scl_y = 256;
  longint win_l = 0, win_t = 0, win_w = 0, win_h = 0;

  prim_t  pending_prims[$];
  int     mismatches = 0;
  int     send_idle = 8;     // percent of idle cycles on the input side
  int     recv_idle = 54;    // percent of stalled cycles on the result side
  int     hold_reqs = 0;     // each increment asks the receiver for one long hold-off
  int     hold_seen = 0;
  int     hold_left = 0;
  longint cycle_count = 0;

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------
  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // (coord - camera) * scale / 256, truncated toward zero, plus origin when enabled
  function automatic longint project(longint c, longint cam, longint sc, longint org, bit en);
    longint q;
    q = ((c - cam) * sc) / 256;
    if (en) q += org;
    return sat16(q);
  endfunction

  // b at a = at on the line through (a0,b0) and (a1,b1)
  function automatic longint lerp_at(longint a0, longint b0, longint a1, longint b1,
                                     longint at);
    longint den, num;
    den = a1 - a0;
    if (den == 0) return b0;
    num = b0 * den + (b1 - b0) * (at - a0);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    return num / den;
  endfunction

  function automatic bit strictly_in(longint x, longint y, longint l, longint r,
                                     longint t, longint b);
    return x > l && x < r && y > t && y < b;
  endfunction

  // moves the outer end onto the crossed border; zero means the edge is dropped
  function automatic bit move_to_border(longint ix, longint iy, inout longint ox,
                                        inout longint oy, input longint l, longint r,
                                        longint t, longint b);
    longint nx, ny;
    if (ox > r || ox < l) begin
      nx = (ox > r) ? r : l;
      ny = lerp_at(ix, iy, ox, oy, nx);
      if (!(ny > t && ny < b)) begin
        ny = (ny <= t) ? t : b;
        nx = lerp_at(iy, ix, oy, ox, ny);
      end
    end else begin
      if (oy <= t) ny = t;
      else if (oy >= b) ny = b;
      else return 1'b0;    // outer end sits on a side border with y inside
      nx = lerp_at(iy, ix, oy, ox, ny);
      if (!(nx > l && nx < r)) return 1'b0;
    end
    ox = nx;
    oy = ny;
    return 1'b1;
  endfunction

  function automatic bit clip_prim(logic k, logic signed [15:0] sx, logic signed [15:0] sy,
                                   logic signed [15:0] ex, logic signed [15:0] ey,
                                   logic [23:0] col, output prim_t res);
    bit     en_x, en_y, on, in1, in2;
    longint l, r, t, b, x1, y1, x2, y2;
    en_x = win_l != 0 && win_w != 0;
    en_y = win_t != 0 && win_h != 0;
    on   = en_x || en_y;
    l = win_l; r = win_l + win_w;
    t = win_t; b = win_t + win_h;
    x1 = project(sx, cam_x, scl_x, win_l, en_x);
    y1 = project(sy, cam_y, scl_y, win_t, en_y);
    res = '0;
    if (k) begin
      if (on && !strictly_in(x1, y1, l, r, t, b)) return 1'b0;
      x2 = x1;
      y2 = y1;
    end else begin
      x2 = project(ex, cam_x, scl_x, win_l, en_x);
      y2 = project(ey, cam_y, scl_y, win_t, en_y);
      if (on) begin
        in1 = strictly_in(x1, y1, l, r, t, b);
        in2 = strictly_in(x2, y2, l, r, t, b);
        if (in1 && !in2) begin
          if (!move_to_border(x1, y1, x2, y2, l, r, t, b)) return 1'b0;
        end else if (!in1 && in2) begin
          if (!move_to_border(x2, y2, x1, y1, l, r, t, b)) return 1'b0;
        end else if (!in1 && !in2) begin
          return 1'b0;
        end
      end
    end
    res.kind = k;
    res.x1 = sat16(x1);
    res.y1 = sat16(y1);
    res.x2 = sat16(x2);
    res.y2 = sat16(y2);
    res.col = col;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // result side: stalls, long hold-off and scoreboard
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    prim_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{out_kind, screen_x1, screen_y1, screen_x2, screen_y2, out_color};
      if (pending_prims.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: %p", got);
      end else begin
        want = pending_prims.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------
  // offers one item, waits for its transfer, then maybe idles
  task automatic send_item(logic k, logic signed [15:0] sx, logic signed [15:0] sy,
                           logic signed [15:0] ex, logic signed [15:0] ey, logic [23:0] col,
                           bit typed, prim_t typed_res);
    prim_t res;
    int    gap;
    in_valid <= 1'b1;
    kind <= k;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    color <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) pending_prims.push_back(typed_res);
    else if (clip_prim(k, sx, sy, ex, ey, col, res)) pending_prims.push_back(res);
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stops offering and waits until the pipeline holds nothing more
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending_prims.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(vsc_reg_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_CAMERA_X:    cam_x = longint'($signed(v));
      REG_CAMERA_Y:    cam_y = longint'($signed(v));
      REG_SCALE_X:     scl_x = v;
      REG_SCALE_Y:     scl_y = v;
      REG_CLIP_LEFT:   win_l = v[14:0];
      REG_CLIP_TOP:    win_t = v[14:0];
      REG_CLIP_WIDTH:  win_w = v[14:0];
      REG_CLIP_HEIGHT: win_h = v[14:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [15:0] cx, logic [15:0] cy, logic [15:0] sx,
                              logic [15:0] sy, logic [15:0] l, logic [15:0] t,
                              logic [15:0] w, logic [15:0] h);
    drain();
    write_reg(REG_CAMERA_X, cx);
    write_reg(REG_CAMERA_Y, cy);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_WIDTH, w);
    write_reg(REG_CLIP_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // world coordinate whose projection lands around the window of one axis
  function automatic logic signed [15:0] near_window(longint cam, longint sc, longint org,
                                                    longint size);
    longint s, rel, c;
    bit     en;
    en  = org != 0 && size != 0;
    s   = org - size / 2 - 3 + longint'($urandom_range(0, 2 * size + 6));
    rel = en ? s - org : s;
    if (sc == 0) return $urandom;
    c = cam + (rel * 256) / sc;
    return sat16(c);
  endfunction

  // directed table: plain rows read straight off the inputs, window rows go to the predictor
  localparam int N_PLAIN = 6;
  localparam int N_DIR   = 19;
  dir_row_t dir_tab [0:N_DIR-1] = '{
    // no clipping after reset: screen equals world, a point repeats its first end
    '{1'b0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 24'hFFFFFF,
      1'b1, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
    '{1'b0, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 24'h000000,
      1'b1, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'h5A5A5A,
      1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{1'b1, 16'sd123, -16'sd77, 16'sd32767, -16'sd32768, 24'hA5A5A5,
      1'b1, 16'sd123, -16'sd77, 16'sd123, -16'sd77},
    '{1'b1, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0, 24'hFFFFFF,
      1'b1, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767},
    '{1'b0, -16'sd1, 16'sd1, 16'sd2, -16'sd2, 24'h800001,
      1'b1, -16'sd1, 16'sd1, 16'sd2, -16'sd2},
    // window 100..300 by 100..200, world + 100 gives screen
    '{1'b0, 16'sd50, 16'sd50, 16'sd150, 16'sd50, 24'h112233, 1'b0, 0, 0, 0, 0},
    '{1'b1, 16'sd10, 16'sd10, 16'sd0, 16'sd0, 24'h445566, 1'b0, 0, 0, 0, 0},
    '{1'b1, -16'sd50, 16'sd0, 16'sd0, 16'sd0, 24'h778899, 1'b0, 0, 0, 0, 0},
    '{1'b1, 16'sd0, 16'sd50, 16'sd0, 16'sd0, 24'h0000AA, 1'b0, 0, 0, 0, 0},
    '{1'b0, 16'sd50, 16'sd50, 16'sd400, 16'sd50, 24'h0000BB, 1'b0, 0, 0, 0, 0},
    '{1'b0, 16'sd50, 16'sd50, -16'sd200, 16'sd30, 24'h0000CC, 1'b0, 0, 0, 0, 0},
    '{1'b0, 16'sd50, 16'sd50, 16'sd60, -16'sd100, 24'h0000DD, 1'b0, 0, 0, 0, 0},
    '{1'b0, 16'sd50, 16'sd50, 16'sd70, 16'sd300, 24'h0000EE, 1'b0, 0, 0, 0, 0},
    '{1'b0, 16'sd190, 16'sd90, 16'sd260, 16'sd200, 24'h0000FF, 1'b0, 0, 0, 0, 0},
    '{1'b0, 16'sd50, 16'sd50, 16'sd0, 16'sd50, 24'h010101, 1'b0, 0, 0, 0, 0},
    '{1'b0, 16'sd50, 16'sd20, 16'sd50, -16'sd300, 24'h020202, 1'b0, 0, 0, 0, 0},
    '{1'b0, -16'sd100, -16'sd100, 16'sd500, 16'sd500, 24'h030303, 1'b0, 0, 0, 0, 0},
    '{1'b0, -16'sd200, 16'sd50, 16'sd50, 16'sd50, 24'h040404, 1'b0, 0, 0, 0, 0}
  };

  initial begin
    prim_t              typed_res;
    int                 done;
    logic               k;
    logic signed [15:0] sx, sy, ex, ey;
    done = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < N_DIR; i++) begin
      if (i == N_PLAIN)
        load_setting(16'd0, 16'd0, 16'd256, 16'd256, 16'd100, 16'd100, 16'd200, 16'd100);
      typed_res = '{dir_tab[i].kind, dir_tab[i].x1, dir_tab[i].y1, dir_tab[i].x2,
                    dir_tab[i].y2, dir_tab[i].col};
      send_item(dir_tab[i].kind, dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex,
                dir_tab[i].ey, dir_tab[i].col, dir_tab[i].typed, typed_res);
    end

    // random part, one register setting after another
    for (int s = 0; s < N_SETS; s++) begin
      case (s)
        0: load_setting(16'd0, 16'd0, 16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0);
        1: load_setting(16'd0, 16'd0, 16'd256, 16'd256, 16'd100, 16'd100, 16'd200, 16'd100);
        2: load_setting(-16'sd500, 16'd300, 16'd512, 16'd128, 16'd1000, 16'd2000,
                        16'd4000, 16'd300);
        // x limit only: the zero-height y window drops everything
        3: load_setting(16'd50, -16'sd50, 16'd256, 16'd256, 16'd300, 16'd0, 16'd500, 16'd0);
        // extremes: borders beyond the coordinate range, scale zero in y
        4: load_setting(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF);
        // tiniest window: only screen (2,2) is inside
        5: load_setting(16'd0, 16'd0, 16'd256, 16'd256, 16'd1, 16'd1, 16'd2, 16'd2);
        6: load_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
        default: load_setting(16'h7FFF, 16'h8000, 16'd1, 16'hFFFF, 16'd5, 16'd7,
                              16'h7FFF, 16'd9);
      endcase
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        // idling: sender light / receiver heavy, then reversed, then none
        if (done < 550) begin
          send_idle = 8; recv_idle = 54;
        end else if (done < 1100) begin
          send_idle = 54; recv_idle = 8;
        end else begin
          send_idle = 0; recv_idle = 0;
        end
        // long hold-off on the result side while items keep coming
        if (s == 1 && n == 60) hold_reqs++;
        // sender pauses until every expected result is out
        if (s == 2 && n == 100 && pending_prims.size() != 0) begin
          in_valid <= 1'b0;
          while (pending_prims.size() != 0) @(posedge clk);
        end
        k = $urandom_range(0, 1);
        if ($urandom_range(99) < 75) begin
          sx = near_window(cam_x, scl_x, win_l, win_w);
          sy = near_window(cam_y, scl_y, win_t, win_h);
          ex = near_window(cam_x, scl_x, win_l, win_w);
          ey = near_window(cam_y, scl_y, win_t, win_h);
        end else begin
          sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
        end
        send_item(k, sx, sy, ex, ey, $urandom, 1'b0, '0);
        done++;
      end
    end

    drain();
    if (mismatches == 0 && pending_prims.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
